// File: hdl/rotate_point_about_axis_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation unit
// Shared property forms for the concurrent checks of the design.
// ----------------------------------------------------------------------------
`ifndef ROTATE_POINT_ABOUT_AXIS_UNIT_MACROS_SVH
`define ROTATE_POINT_ABOUT_AXIS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// Rotation unit package
// Types, constants and the arctangent table shared by the rotation unit.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int CW = 36;
  localparam int ATAN_LEN = 30;

  typedef logic signed [CW-1:0] cval_t;

  localparam cval_t PI_Q30      = 36'sd3373259426;
  localparam cval_t HALF_PI_Q30 = 36'sd1686629713;
  localparam cval_t TWO_PI_Q30  = 36'sd6746518852;
  localparam cval_t GAIN_Q30    = 36'sd652032874;

  typedef struct packed {
    logic signed [32:0] px;
    logic signed [32:0] py;
    logic signed [32:0] pz;
    logic signed [17:0] kx;
    logic signed [17:0] ky;
    logic signed [17:0] kz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } rpa_geom_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
    logic  flip;
  } rpa_rot_t;

  typedef struct packed {
    logic      valid;
    rpa_rot_t  rot;
    rpa_geom_t geom;
  } rpa_cell_t;

  function automatic cval_t atan_q30(input int unsigned i);
    cval_t v;
    case (i)
      0:  v = 36'sd843314857;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043837;
      3:  v = 36'sd133525159;
      4:  v = 36'sd67021687;
      5:  v = 36'sd33543516;
      6:  v = 36'sd16775851;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194283;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048576;
      11: v = 36'sd524288;
      12: v = 36'sd262144;
      13: v = 36'sd131072;
      14: v = 36'sd65536;
      15: v = 36'sd32768;
      16: v = 36'sd16384;
      17: v = 36'sd8192;
      18: v = 36'sd4096;
      19: v = 36'sd2048;
      20: v = 36'sd1024;
      21: v = 36'sd512;
      22: v = 36'sd256;
      23: v = 36'sd128;
      24: v = 36'sd64;
      25: v = 36'sd32;
      26: v = 36'sd16;
      27: v = 36'sd8;
      28: v = 36'sd4;
      29: v = 36'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/rpa_in_if.sv
// ----------------------------------------------------------------------------
// Rotation unit input channel
// Valid/ready channel carrying one point, angle, axis and pivot.
// ----------------------------------------------------------------------------
interface rpa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [19:0] rot_angle;
  logic signed [17:0] axis_x;
  logic signed [17:0] axis_y;
  logic signed [17:0] axis_z;
  logic signed [31:0] pivot_x;
  logic signed [31:0] pivot_y;
  logic signed [31:0] pivot_z;

  modport source (output valid, point_x, point_y, point_z, rot_angle, axis_x, axis_y,
                  axis_z, pivot_x, pivot_y, pivot_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, rot_angle, axis_x, axis_y,
                axis_z, pivot_x, pivot_y, pivot_z, output ready);
endinterface

// File: hdl/rpa_out_if.sv
// ----------------------------------------------------------------------------
// Rotation unit output channel
// Valid/ready channel carrying one rotated point.
// ----------------------------------------------------------------------------
interface rpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotated_x;
  logic signed [31:0] rotated_y;
  logic signed [31:0] rotated_z;

  modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
  modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// File: hdl/rpa_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation of the sine and cosine chain, passing the geometry along.
// ----------------------------------------------------------------------------
module rpa_cordic_cell
  import rpa_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  rpa_cell_t cell_in,
  output rpa_cell_t cell_out
);

  cval_t     xs;
  cval_t     ys;
  rpa_cell_t nxt;

  always_comb begin
    xs  = cell_in.rot.x >>> STEP;
    ys  = cell_in.rot.y >>> STEP;
    nxt = cell_in;
    if (!cell_in.rot.z[CW-1]) begin
      nxt.rot.x = cell_in.rot.x - ys;
      nxt.rot.y = cell_in.rot.y + xs;
      nxt.rot.z = cell_in.rot.z - atan_q30(STEP);
    end else begin
      nxt.rot.x = cell_in.rot.x + ys;
      nxt.rot.y = cell_in.rot.y - xs;
      nxt.rot.z = cell_in.rot.z + atan_q30(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (adv) begin
      cell_out <= nxt;
    end
  end

endmodule

// File: hdl/rpa_post.sv
// ----------------------------------------------------------------------------
// Rodrigues combine pipeline
// Dot and cross products, the axis term and the final saturated sum.
// ----------------------------------------------------------------------------
module rpa_post
  import rpa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  rpa_cell_t          cell_in,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  localparam int SH    = 30 - FRAC_BITS;
  localparam int CS_W  = FRAC_BITS + 3;
  localparam int KP_W  = 51;
  localparam int DW    = 54 - FRAC_BITS;
  localparam int OMC_W = CS_W + 1;
  localparam int DT_W  = DW + OMC_W;
  localparam int CP_W  = CS_W + 33;
  localparam int SQ_W  = CS_W + DW;
  localparam int TW    = DT_W - FRAC_BITS + 1;
  localparam int TK_W  = TW + 18;

  localparam logic signed [63:0] HALF_SH = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] HALF_FB = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE_FB  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // Stage A: sine, cosine and the nine axis-by-point products.
  logic                   va;
  logic signed [CS_W-1:0] c_a, s_a;
  logic signed [KP_W-1:0] kxpx, kypy, kzpz, kypz, kzpy, kzpx, kxpz, kxpy, kypx;
  rpa_geom_t              g_a;
  cval_t                  fx, fy;
  logic signed [63:0]     cw, sw;

  always_comb begin
    fx = cell_in.rot.flip ? -cell_in.rot.x : cell_in.rot.x;
    fy = cell_in.rot.flip ? -cell_in.rot.y : cell_in.rot.y;
    cw = (64'(fx) + HALF_SH) >>> SH;
    sw = (64'(fy) + HALF_SH) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va   <= cell_in.valid;
      c_a  <= CS_W'(cw);
      s_a  <= CS_W'(sw);
      g_a  <= cell_in.geom;
      kxpx <= KP_W'(cell_in.geom.kx) * KP_W'(cell_in.geom.px);
      kypy <= KP_W'(cell_in.geom.ky) * KP_W'(cell_in.geom.py);
      kzpz <= KP_W'(cell_in.geom.kz) * KP_W'(cell_in.geom.pz);
      kypz <= KP_W'(cell_in.geom.ky) * KP_W'(cell_in.geom.pz);
      kzpy <= KP_W'(cell_in.geom.kz) * KP_W'(cell_in.geom.py);
      kzpx <= KP_W'(cell_in.geom.kz) * KP_W'(cell_in.geom.px);
      kxpz <= KP_W'(cell_in.geom.kx) * KP_W'(cell_in.geom.pz);
      kxpy <= KP_W'(cell_in.geom.kx) * KP_W'(cell_in.geom.py);
      kypx <= KP_W'(cell_in.geom.ky) * KP_W'(cell_in.geom.px);
    end
  end

  // Stage B: rounded dot product, cross product and one minus cosine.
  logic                    vb;
  logic signed [CS_W-1:0]  c_b, s_b;
  logic signed [DW-1:0]    d_b, qx_b, qy_b, qz_b;
  logic signed [OMC_W-1:0] omc_b;
  rpa_geom_t               g_b;
  logic signed [63:0]      dsum, qxs, qys, qzs, omcw;

  always_comb begin
    dsum = 64'(kxpx) + 64'(kypy) + 64'(kzpz) + HALF_FB;
    qxs  = 64'(kypz) - 64'(kzpy) + HALF_FB;
    qys  = 64'(kzpx) - 64'(kxpz) + HALF_FB;
    qzs  = 64'(kxpy) - 64'(kypx) + HALF_FB;
    omcw = ONE_FB - 64'(c_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb    <= va;
      c_b   <= c_a;
      s_b   <= s_a;
      g_b   <= g_a;
      d_b   <= DW'(dsum >>> FRAC_BITS);
      qx_b  <= DW'(qxs >>> FRAC_BITS);
      qy_b  <= DW'(qys >>> FRAC_BITS);
      qz_b  <= DW'(qzs >>> FRAC_BITS);
      omc_b <= OMC_W'(omcw);
    end
  end

  // Stage C: axis term product and the cosine and sine terms.
  logic                   vc;
  logic signed [DT_W-1:0] dt_c;
  logic signed [CP_W-1:0] cpx_c, cpy_c, cpz_c;
  logic signed [SQ_W-1:0] sqx_c, sqy_c, sqz_c;
  rpa_geom_t              g_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc    <= vb;
      g_c   <= g_b;
      dt_c  <= DT_W'(d_b) * DT_W'(omc_b);
      cpx_c <= CP_W'(c_b) * CP_W'(g_b.px);
      cpy_c <= CP_W'(c_b) * CP_W'(g_b.py);
      cpz_c <= CP_W'(c_b) * CP_W'(g_b.pz);
      sqx_c <= SQ_W'(s_b) * SQ_W'(qx_b);
      sqy_c <= SQ_W'(s_b) * SQ_W'(qy_b);
      sqz_c <= SQ_W'(s_b) * SQ_W'(qz_b);
    end
  end

  // Stage D: rounded axis scale times each axis component.
  logic                   vd;
  logic signed [TK_W-1:0] tkx_d, tky_d, tkz_d;
  logic signed [CP_W-1:0] cpx_d, cpy_d, cpz_d;
  logic signed [SQ_W-1:0] sqx_d, sqy_d, sqz_d;
  logic signed [31:0]     vx_d, vy_d, vz_d;
  logic signed [63:0]     tw;
  logic signed [TW-1:0]   t_c;

  always_comb begin
    tw  = (64'(dt_c) + HALF_FB) >>> FRAC_BITS;
    t_c = TW'(tw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd    <= vc;
      tkx_d <= TK_W'(t_c) * TK_W'(g_c.kx);
      tky_d <= TK_W'(t_c) * TK_W'(g_c.ky);
      tkz_d <= TK_W'(t_c) * TK_W'(g_c.kz);
      cpx_d <= cpx_c;
      cpy_d <= cpy_c;
      cpz_d <= cpz_c;
      sqx_d <= sqx_c;
      sqy_d <= sqy_c;
      sqz_d <= sqz_c;
      vx_d  <= g_c.vx;
      vy_d  <= g_c.vy;
      vz_d  <= g_c.vz;
    end
  end

  // Stage E: sum, round, add the pivot back and saturate.
  logic signed [63:0] rx, ry, rz;
  logic signed [31:0] sx, sy, sz;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] w;
    w = v;
    if (w > SAT_MAX) begin
      w = SAT_MAX;
    end
    if (w < SAT_MIN) begin
      w = SAT_MIN;
    end
    return w[31:0];
  endfunction

  always_comb begin
    rx = ((64'(cpx_d) + 64'(tkx_d) + 64'(sqx_d) + HALF_FB) >>> FRAC_BITS) + 64'(vx_d);
    ry = ((64'(cpy_d) + 64'(tky_d) + 64'(sqy_d) + HALF_FB) >>> FRAC_BITS) + 64'(vy_d);
    rz = ((64'(cpz_d) + 64'(tkz_d) + 64'(sqz_d) + HALF_FB) >>> FRAC_BITS) + 64'(vz_d);
    sx = sat32(rx);
    sy = sat32(ry);
    sz = sat32(rz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd;
      out_x     <= sx;
      out_y     <= sy;
      out_z     <= sz;
    end
  end

endmodule

// File: hdl/rotate_point_about_axis_unit.sv
// ----------------------------------------------------------------------------
// Rotate point about axis unit
// Throughput is one transaction per cycle; the whole pipeline holds while a
// finished result waits at the output and is not taken.
// Reset clears every pipeline valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "rotate_point_about_axis_unit_macros.svh"

module rotate_point_about_axis_unit
  import rpa_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input logic  clk,
  input logic  rst,
  rpa_in_if.sink    items,
  rpa_out_if.source results
);

  localparam int NC  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int SH  = 30 - FRAC_BITS;
  localparam int RED = (FRAC_BITS < 16) ? (17 - FRAC_BITS) : 1;

  localparam logic signed [63:0] PI64      = 64'(PI_Q30);
  localparam logic signed [63:0] HALF_PI64 = 64'(HALF_PI_Q30);
  localparam logic signed [63:0] TWO_PI64  = 64'(TWO_PI_Q30);

  logic               adv;
  logic               neg;
  logic               flip;
  logic signed [63:0] za, zm, zr;
  rpa_cell_t          chain [NC+1];

  assign adv         = !results.valid || results.ready;
  assign items.ready = adv;

  always_comb begin
    za   = 64'(items.rot_angle) <<< SH;
    neg  = za[63];
    zm   = neg ? -za : za;
    for (int j = RED - 1; j >= 0; j--) begin
      if (zm >= (TWO_PI64 <<< j)) begin
        zm = zm - (TWO_PI64 <<< j);
      end
    end
    zr   = neg ? -zm : zm;
    flip = 1'b0;
    if (zr > PI64) begin
      zr = zr - TWO_PI64;
    end
    if (zr < -PI64) begin
      zr = zr + TWO_PI64;
    end
    if (zr > HALF_PI64) begin
      zr   = zr - PI64;
      flip = 1'b1;
    end else if (zr < -HALF_PI64) begin
      zr   = zr + PI64;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid     <= items.valid;
      chain[0].rot.x     <= GAIN_Q30;
      chain[0].rot.y     <= '0;
      chain[0].rot.z     <= CW'(zr);
      chain[0].rot.flip  <= flip;
      chain[0].geom.px   <= 33'(items.point_x) - 33'(items.pivot_x);
      chain[0].geom.py   <= 33'(items.point_y) - 33'(items.pivot_y);
      chain[0].geom.pz   <= 33'(items.point_z) - 33'(items.pivot_z);
      chain[0].geom.kx   <= items.axis_x;
      chain[0].geom.ky   <= items.axis_y;
      chain[0].geom.kz   <= items.axis_z;
      chain[0].geom.vx   <= items.pivot_x;
      chain[0].geom.vy   <= items.pivot_y;
      chain[0].geom.vz   <= items.pivot_z;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rpa_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .cell_in (chain[i]),
      .cell_out(chain[i+1])
    );
  end

  rpa_post #(
    .FRAC_BITS(FRAC_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cell_in  (chain[NC]),
    .out_valid(results.valid),
    .out_x    (results.rotated_x),
    .out_y    (results.rotated_y),
    .out_z    (results.rotated_z)
  );

  `RPA_ASSERT_NEXT(a_accept_enters, clk, rst, items.valid && items.ready, chain[0].valid, "Accepted transaction did not enter the pipeline.")
  `RPA_ASSERT_IMPLY(a_fold_range, clk, rst, chain[0].valid, (chain[0].rot.z <= HALF_PI_Q30) && (chain[0].rot.z >= -HALF_PI_Q30), "Folded angle outside the half-pi range.")
  `RPA_ASSERT_NEXT(a_stall_holds, clk, rst, !adv && chain[NC].valid, chain[NC].valid, "Pipeline lost a transaction while stalled.")

endmodule
